FILE: rtl/core/assert_macros.svh
// Assertion helpers used by smsc_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SMSC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("smsc: assertion failed");

// Check a property on every rising edge, reset included.
`define SMSC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("smsc: assertion failed");

`endif

FILE: rtl/core/smsc_pkg.sv
package smsc_pkg;

  localparam int COORD_BITS    = 10;
  localparam int LABEL_BITS    = 6;
  localparam int PIX_BITS      = 8;
  localparam int COST_BITS     = 9;
  localparam int SIZE_BITS     = 9;
  localparam int SHIFT_BITS    = 2 * COORD_BITS;
  localparam int PLACES        = 4;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [COST_BITS-1:0] INVALID_COST = COST_BITS'(100);
  localparam logic [COST_BITS-1:0] ZERO_COST    = '0;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET   = SIZE_BITS'(256);

  // Placement slots of a pairwise query, in image read order.
  localparam logic [1:0] PL_P1_L1 = 2'd0;
  localparam logic [1:0] PL_P1_L2 = 2'd1;
  localparam logic [1:0] PL_P2_L1 = 2'd2;
  localparam logic [1:0] PL_P2_L2 = 2'd3;

  typedef enum logic [1:0] {
    OP_PIX_WR   = 2'd0,
    OP_SHIFT_WR = 2'd1,
    OP_UNARY    = 2'd2,
    OP_PAIR     = 2'd3
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                                op;
    logic                               use_mem;
    logic [COST_BITS-1:0]               imm_cost;
    logic [PLACES-1:0][COORD_BITS-1:0]  px;
    logic [PLACES-1:0][COORD_BITS-1:0]  py;
    logic [PIX_BITS-1:0]                value;
  } pix_job_t;

  typedef struct packed {
    logic [COST_BITS-1:0] cost;
    logic                 is_pairwise;
  } result_t;

  function automatic logic [PIX_BITS-1:0] absdiff(input logic [PIX_BITS-1:0] a,
                                                  input logic [PIX_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

FILE: rtl/core/smsc_if.sv
interface smsc_query_if import smsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [COORD_BITS-1:0] first_node_x;
  logic [COORD_BITS-1:0] first_node_y;
  logic [COORD_BITS-1:0] second_node_x;
  logic [COORD_BITS-1:0] second_node_y;
  logic [LABEL_BITS-1:0] first_label;
  logic [LABEL_BITS-1:0] second_label;
  logic [PIX_BITS-1:0]   pixel_value;
  logic [COORD_BITS-1:0] shift_dx;
  logic [COORD_BITS-1:0] shift_dy;

  modport source (
    output valid, opcode, first_node_x, first_node_y, second_node_x, second_node_y,
           first_label, second_label, pixel_value, shift_dx, shift_dy,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_node_x, first_node_y, second_node_x, second_node_y,
           first_label, second_label, pixel_value, shift_dx, shift_dy,
    output ready
  );
endinterface

interface smsc_result_if import smsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] cost;
  logic                 is_pairwise;

  modport source (output valid, cost, is_pairwise, input ready);
  modport sink (input valid, cost, is_pairwise, output ready);
endinterface

FILE: rtl/core/smsc_cfg.sv
module smsc_cfg import smsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [SIZE_BITS-1:0]     image_width,
  output logic [SIZE_BITS-1:0]     image_height
);

  reg_idx_t sel;
  logic     wr;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (wr) begin
      unique case (sel)
        REG_WIDTH:  image_width  <= pwdata[SIZE_BITS-1:0];
        REG_HEIGHT: image_height <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_WIDTH:  prdata = APB_DATA_BITS'(image_width);
      REG_HEIGHT: prdata = APB_DATA_BITS'(image_height);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/smsc_place.sv
module smsc_place import smsc_pkg::*; #(
  parameter int MAX_IMAGE_SIDE = 256,
  parameter int MAX_LABELS     = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  smsc_query_if.sink           query,
  input  logic [SIZE_BITS-1:0] image_width,
  input  logic [SIZE_BITS-1:0] image_height,
  output logic                 job_valid,
  output pix_job_t             job,
  input  logic                 job_take
);

  localparam int LBL_AW = $clog2(MAX_LABELS);

  logic [SHIFT_BITS-1:0] shift_mem [MAX_LABELS];

  logic                  s1_valid;
  op_t                   s1_op;
  logic [COORD_BITS-1:0] s1_x1, s1_y1, s1_x2, s1_y2;
  logic [LABEL_BITS-1:0] s1_l1, s1_l2;
  logic [PIX_BITS-1:0]   s1_pv;
  logic [SHIFT_BITS-1:0] sh1, sh2;

  logic                  accept;
  op_t                   in_op;
  logic                  in_l1_ok;
  logic [LBL_AW+LABEL_BITS-1:0] ia_ext, ib_ext;
  logic [LBL_AW-1:0]     ia, ib;

  logic                  l1_ok, l2_ok;
  logic [COORD_BITS:0]   xa, ya, xc, yc, xe, ye, xb, yb;
  logic                  ok_a, ok_c, ok_e, ok_b;

  // One axis of a placement: {inside, position}.
  function automatic logic [COORD_BITS:0] axis(input logic [COORD_BITS-1:0] n,
                                               input logic [COORD_BITS-1:0] s,
                                               input logic [SIZE_BITS-1:0]  lim);
    logic [COORD_BITS-1:0] d;
    logic                  ok;
    d  = n - s;
    ok = (n >= s) && (d < COORD_BITS'(lim)) && (32'(d) < MAX_IMAGE_SIDE);
    return {ok, d};
  endfunction

  assign query.ready = !s1_valid || job_take;
  assign accept      = query.valid && query.ready;
  assign in_op       = op_t'(query.opcode);
  assign in_l1_ok    = 32'(query.first_label) < MAX_LABELS;
  assign ia_ext      = {{LBL_AW{1'b0}}, query.first_label};
  assign ib_ext      = {{LBL_AW{1'b0}}, query.second_label};
  assign ia          = ia_ext[LBL_AW-1:0];
  assign ib          = ib_ext[LBL_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (in_op != OP_SHIFT_WR);
    end else if (job_take) begin
      s1_valid <= 1'b0;
    end
  end

  // Read both shifts as the item comes in; a shift write stores here.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= in_op;
      s1_x1 <= query.first_node_x;
      s1_y1 <= query.first_node_y;
      s1_x2 <= query.second_node_x;
      s1_y2 <= query.second_node_y;
      s1_l1 <= query.first_label;
      s1_l2 <= query.second_label;
      s1_pv <= query.pixel_value;
      sh1   <= shift_mem[ia];
      sh2   <= shift_mem[ib];
      if (in_op == OP_SHIFT_WR && in_l1_ok) begin
        shift_mem[ia] <= {query.shift_dx, query.shift_dy};
      end
    end
  end

  assign l1_ok = 32'(s1_l1) < MAX_LABELS;
  assign l2_ok = 32'(s1_l2) < MAX_LABELS;

  assign xa = axis(s1_x1, sh1[SHIFT_BITS-1 -: COORD_BITS], image_width);
  assign ya = axis(s1_y1, sh1[COORD_BITS-1:0], image_height);
  assign xc = axis(s1_x1, sh2[SHIFT_BITS-1 -: COORD_BITS], image_width);
  assign yc = axis(s1_y1, sh2[COORD_BITS-1:0], image_height);
  assign xe = axis(s1_x2, sh1[SHIFT_BITS-1 -: COORD_BITS], image_width);
  assign ye = axis(s1_y2, sh1[COORD_BITS-1:0], image_height);
  assign xb = axis(s1_x2, sh2[SHIFT_BITS-1 -: COORD_BITS], image_width);
  assign yb = axis(s1_y2, sh2[COORD_BITS-1:0], image_height);

  assign ok_a = l1_ok && xa[COORD_BITS] && ya[COORD_BITS];
  assign ok_c = l2_ok && xc[COORD_BITS] && yc[COORD_BITS];
  assign ok_e = l1_ok && xe[COORD_BITS] && ye[COORD_BITS];
  assign ok_b = l2_ok && xb[COORD_BITS] && yb[COORD_BITS];

  assign job_valid = s1_valid;

  always_comb begin
    job.op           = s1_op;
    job.value        = s1_pv;
    job.px[PL_P1_L1] = xa[COORD_BITS-1:0];
    job.py[PL_P1_L1] = ya[COORD_BITS-1:0];
    job.px[PL_P1_L2] = xc[COORD_BITS-1:0];
    job.py[PL_P1_L2] = yc[COORD_BITS-1:0];
    job.px[PL_P2_L1] = xe[COORD_BITS-1:0];
    job.py[PL_P2_L1] = ye[COORD_BITS-1:0];
    job.px[PL_P2_L2] = xb[COORD_BITS-1:0];
    job.py[PL_P2_L2] = yb[COORD_BITS-1:0];
    job.use_mem      = 1'b0;
    job.imm_cost     = ZERO_COST;
    case (s1_op)
      OP_PIX_WR: begin
        job.px[PL_P1_L1] = s1_x1;
        job.py[PL_P1_L1] = s1_y1;
        job.use_mem = (32'(s1_x1) < MAX_IMAGE_SIDE) && (32'(s1_y1) < MAX_IMAGE_SIDE);
      end
      OP_UNARY: begin
        job.imm_cost = ok_a ? ZERO_COST : INVALID_COST;
      end
      OP_PAIR: begin
        job.use_mem  = (s1_l1 != s1_l2) && ok_a && ok_c && ok_e && ok_b;
        job.imm_cost = (s1_l1 == s1_l2) ? ZERO_COST : INVALID_COST;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/smsc_pix.sv
module smsc_pix import smsc_pkg::*; #(
  parameter int MAX_IMAGE_SIDE = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  input  pix_job_t job,
  output logic     job_take,
  input  logic     advance,
  output logic     push,
  output result_t  push_data
);

  localparam int SIDE_AW   = $clog2(MAX_IMAGE_SIDE);
  localparam int IMG_DEPTH = 1 << (2 * SIDE_AW);

  logic [PIX_BITS-1:0] img_mem [IMG_DEPTH];

  // Issue stage
  logic                  e_valid;
  pix_job_t              e_job;
  logic [1:0]            e_cnt;
  logic                  e_pairmem, e_done;
  logic [COORD_BITS-1:0] sel_x, sel_y;
  logic [2*SIDE_AW-1:0]  addr;
  logic                  mem_we, mem_re;

  // Read return and accumulation
  logic                rtag_valid;
  logic [1:0]          rtag_idx;
  logic [PIX_BITS-1:0] rdata, d0, diff0;

  // Result stage
  logic                 r_valid, r_has_res, r_use_mem, r_is_pair;
  logic [COST_BITS-1:0] r_imm;

  assign e_pairmem = (e_job.op == OP_PAIR) && e_job.use_mem;
  assign e_done    = e_valid && (!e_pairmem || e_cnt == PL_P2_L2);
  assign job_take  = advance && (!e_valid || e_done);

  assign sel_x  = e_job.px[e_cnt];
  assign sel_y  = e_job.py[e_cnt];
  assign addr   = {sel_y[SIDE_AW-1:0], sel_x[SIDE_AW-1:0]};
  assign mem_we = advance && e_valid && (e_job.op == OP_PIX_WR) && e_job.use_mem;
  assign mem_re = advance && e_valid && e_pairmem;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      img_mem[addr] <= e_job.value;
    end
    if (mem_re) begin
      rdata <= img_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid    <= 1'b0;
      e_cnt      <= '0;
      rtag_valid <= 1'b0;
      r_valid    <= 1'b0;
    end else if (advance) begin
      if (job_take) begin
        e_valid <= job_valid;
        e_cnt   <= '0;
      end else if (e_pairmem) begin
        e_cnt <= e_cnt + 2'd1;
      end
      rtag_valid <= mem_re;
      r_valid    <= e_done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (job_take) begin
        e_job <= job;
      end
      rtag_idx  <= e_cnt;
      r_has_res <= (e_job.op == OP_UNARY) || (e_job.op == OP_PAIR);
      r_use_mem <= e_pairmem;
      r_is_pair <= (e_job.op == OP_PAIR);
      r_imm     <= e_job.imm_cost;
      // Fold returning pixels: |p1l1 - p1l2| first, then hold p2l1.
      if (rtag_valid) begin
        case (rtag_idx)
          PL_P1_L1: d0    <= rdata;
          PL_P1_L2: diff0 <= absdiff(d0, rdata);
          PL_P2_L1: d0    <= rdata;
          default: ;
        endcase
      end
    end
  end

  assign push = advance && r_valid && r_has_res;

  always_comb begin
    push_data.is_pairwise = r_is_pair;
    if (r_use_mem) begin
      push_data.cost = COST_BITS'({1'b0, diff0} + {1'b0, absdiff(d0, rdata)});
    end else begin
      push_data.cost = r_imm;
    end
  end

endmodule

FILE: rtl/core/smsc_outq.sv
module smsc_outq import smsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  output logic       push_ok,
  smsc_result_if.source result
);

  logic    head_v, tail_v;
  result_t head, tail;
  logic    pop;

  assign pop                = head_v && result.ready;
  assign push_ok            = !(head_v && tail_v);
  assign result.valid       = head_v;
  assign result.cost        = head.cost;
  assign result.is_pairwise = head.is_pairwise;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      tail_v <= 1'b0;
    end else if (pop) begin
      head_v <= tail_v || push;
      tail_v <= tail_v && push;
    end else if (!head_v) begin
      head_v <= push;
    end else if (!tail_v) begin
      tail_v <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head <= tail_v ? tail : push_data;
      tail <= push_data;
    end else if (!head_v) begin
      head <= push_data;
    end else if (!tail_v) begin
      tail <= push_data;
    end
  end

endmodule

FILE: rtl/core/shift_map_seam_cost.sv
// Seam cost engine for shift-map image synthesis.
// Query channel: one item per handshake. Opcode 0 writes a source pixel,
// 1 writes a label shift, 2 asks the unary cost of a node under a label, 3 asks
// the pairwise cost of two neighbor nodes under two labels. Writes give no
// result; each query gives one item on the result channel (cost, is_pairwise).
// APB port: image_width at 0x0, image_height at 0x4, reset 256 each; write them
// only while no query is in flight.
// A query's result passes the placement register, the issue stage, the result
// stage and the result queue. Throughput: one item a cycle for writes, unary
// queries and pairwise queries that need no pixels, while the result queue has
// room; a pairwise query with distinct labels whose four placements fall inside
// holds the image unit for one read per placement, set by the single port of
// the image memory. Both shifts are read in the same cycle from two read ports.
// Reset empties the pipeline and the result queue; the image and the shift
// table keep no reset state and must be written before they are read.
// A stalled receiver fills the two-entry result queue; then the pipeline
// holds and query.ready drops until the queue drains.
module shift_map_seam_cost import smsc_pkg::*; #(
  parameter int MAX_IMAGE_SIDE = 256,
  parameter int MAX_LABELS     = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  smsc_query_if.sink               query,
  smsc_result_if.source            result
);

  logic [SIZE_BITS-1:0] image_width;
  logic [SIZE_BITS-1:0] image_height;

  logic     job_valid;
  pix_job_t job;
  logic     job_take;

  logic     push;
  result_t  push_data;
  logic     push_ok;

  // Size registers and APB decode.
  smsc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // Accept items, read both shifts, compute the four placements.
  smsc_place #(
    .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
    .MAX_LABELS     (MAX_LABELS)
  ) u_place (
    .clk          (clk),
    .rst          (rst),
    .query        (query),
    .image_width  (image_width),
    .image_height (image_height),
    .job_valid    (job_valid),
    .job          (job),
    .job_take     (job_take)
  );

  // Image memory: pixel writes and up to four reads per pairwise query.
  // Everything downstream of the shift read advances only while the
  // result queue has room.
  smsc_pix #(
    .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
  ) u_pix (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .advance   (push_ok),
    .push      (push),
    .push_data (push_data)
  );

  // Two-entry result queue decouples the receiver from the pipeline.
  smsc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .push_ok   (push_ok),
    .result    (result)
  );

endmodule

FILE: rtl/core/smsc_checker.sv
`include "assert_macros.svh"

module smsc_checker import smsc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 valid,
  input logic                 ready,
  input logic [COST_BITS-1:0] cost,
  input logic                 is_pairwise
);

  `SMSC_ASSERT(a_valid_holds, clk, rst, valid && !ready |=> valid)
  `SMSC_ASSERT(a_item_holds, clk, rst, valid && !ready |=> $stable(cost) && $stable(is_pairwise))
  `SMSC_ASSERT(a_unary_cost, clk, rst, valid && !is_pairwise |-> cost == ZERO_COST || cost == INVALID_COST)
  `SMSC_ASSERT(a_cost_range, clk, rst, valid |-> cost <= COST_BITS'(510))
  `SMSC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !valid)

endmodule

bind shift_map_seam_cost smsc_checker u_smsc_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .cost        (result.cost),
  .is_pairwise (result.is_pairwise)
);

FILE: test/seam_tb_pkg.sv
`timescale 1ns / 1ps
package seam_tb_pkg;
  import smsc_pkg::*;

  localparam int IMAGE_SIDE = 256;
  localparam int LABELS     = 1 << LABEL_BITS;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y2;
    logic [LABEL_BITS-1:0] l1;
    logic [LABEL_BITS-1:0] l2;
    logic [PIX_BITS-1:0]   value;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
  } seam_item_t;

  // Size register as the block uses it: clamp to the stored image side.
  function automatic int used_side(input logic [SIZE_BITS-1:0] size);
    return (int'(size) > IMAGE_SIDE) ? IMAGE_SIDE : int'(size);
  endfunction

  // Shift a node back by a label's shift; true when it lands in the image in use.
  function automatic bit lands_inside(input logic [COORD_BITS-1:0] nx, ny, sx, sy,
                                      input int w, h,
                                      output logic [PIX_BITS-1:0] px, py);
    int dx, dy;
    dx = int'(nx) - int'(sx);
    dy = int'(ny) - int'(sy);
    px = PIX_BITS'(dx);
    py = PIX_BITS'(dy);
    return dx >= 0 && dy >= 0 && dx < w && dy < h;
  endfunction

endpackage

FILE: test/seam_cost_checker.sv
`timescale 1ns / 1ps
module seam_cost_checker import smsc_pkg::*; import seam_tb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic                     pready,
  smsc_query_if                    qry,
  smsc_result_if                   res,
  output int                       mismatches,
  output int                       outstanding
);

  logic [PIX_BITS-1:0]   gray     [IMAGE_SIDE*IMAGE_SIDE];
  logic [COORD_BITS-1:0] shift_dx [LABELS];
  logic [COORD_BITS-1:0] shift_dy [LABELS];
  logic [SIZE_BITS-1:0]  width;
  logic [SIZE_BITS-1:0]  height;

  result_t    expected_costs[$];
  result_t    want;
  result_t    got;
  seam_item_t seen;
  int         fails = 0;

  // Cost of one query against the current image, shift table and size.
  function automatic result_t seam_energy(input seam_item_t it);
    result_t r;
    logic [PIX_BITS-1:0] ax, ay, bx, by, cx, cy, ex, ey;
    bit in_a, in_b, in_c, in_e;
    int w, h, gap1, gap2;
    w = used_side(width);
    h = used_side(height);
    r.is_pairwise = (it.op == OP_PAIR);
    in_a = lands_inside(it.x1, it.y1, shift_dx[it.l1], shift_dy[it.l1], w, h, ax, ay);
    if (it.op == OP_UNARY) begin
      r.cost = in_a ? ZERO_COST : INVALID_COST;
    end else if (it.l1 == it.l2) begin
      r.cost = ZERO_COST;
    end else begin
      in_b = lands_inside(it.x2, it.y2, shift_dx[it.l2], shift_dy[it.l2], w, h, bx, by);
      in_c = lands_inside(it.x1, it.y1, shift_dx[it.l2], shift_dy[it.l2], w, h, cx, cy);
      in_e = lands_inside(it.x2, it.y2, shift_dx[it.l1], shift_dy[it.l1], w, h, ex, ey);
      if (in_a && in_b && in_c && in_e) begin
        gap1 = int'(gray[{ay, ax}]) - int'(gray[{cy, cx}]);
        gap2 = int'(gray[{ey, ex}]) - int'(gray[{by, bx}]);
        if (gap1 < 0) gap1 = -gap1;
        if (gap2 < 0) gap2 = -gap2;
        r.cost = COST_BITS'(gap1 + gap2);
      end else begin
        r.cost = INVALID_COST;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width  = SIZE_RESET;
      height = SIZE_RESET;
      expected_costs.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_idx_t'(paddr[2]))
          REG_WIDTH:  width  = pwdata[SIZE_BITS-1:0];
          REG_HEIGHT: height = pwdata[SIZE_BITS-1:0];
        endcase
      end

      if (res.valid && res.ready) begin
        got.cost        = res.cost;
        got.is_pairwise = res.is_pairwise;
        if (expected_costs.size() == 0) begin
          $error("result with nothing expected: cost %0d, is_pairwise %0d",
                 got.cost, got.is_pairwise);
          fails++;
        end else begin
          want = expected_costs.pop_front();
          if (got.cost !== want.cost) begin
            $error("cost mismatch: expected %0d, actual %0d", want.cost, got.cost);
            fails++;
          end
          if (got.is_pairwise !== want.is_pairwise) begin
            $error("is_pairwise mismatch: expected %0d, actual %0d",
                   want.is_pairwise, got.is_pairwise);
            fails++;
          end
        end
      end

      if (qry.valid && qry.ready) begin
        seen.op    = op_t'(qry.opcode);
        seen.x1    = qry.first_node_x;
        seen.y1    = qry.first_node_y;
        seen.x2    = qry.second_node_x;
        seen.y2    = qry.second_node_y;
        seen.l1    = qry.first_label;
        seen.l2    = qry.second_label;
        seen.value = qry.pixel_value;
        seen.dx    = qry.shift_dx;
        seen.dy    = qry.shift_dy;
        case (seen.op)
          OP_PIX_WR: begin
            if (seen.x1 < IMAGE_SIDE && seen.y1 < IMAGE_SIDE)
              gray[{seen.y1[7:0], seen.x1[7:0]}] = seen.value;
          end
          OP_SHIFT_WR: begin
            shift_dx[seen.l1] = seen.dx;
            shift_dy[seen.l1] = seen.dy;
          end
          default: expected_costs.push_back(seam_energy(seen));
        endcase
      end

      mismatches  <= fails;
      outstanding <= expected_costs.size();
    end
  end

endmodule

FILE: test/tb_shift_map_seam_cost.sv
`timescale 1ns / 1ps
module tb_shift_map_seam_cost;
  import smsc_pkg::*;
  import seam_tb_pkg::*;

  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 140;
  localparam int IDLE_PCT      = 34;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES  = 20;
  // ~1400 items incl. pixel preloads, even with both sides idling, fit well
  // within the limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT   = 500000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  smsc_query_if  qry ();
  smsc_result_if res ();

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int src_idle_pct;
  int snk_idle_pct;
  bit hold_request;

  // Stimulus-side view of what has been loaded, used only to aim queries
  // and to make sure no pairwise query ever reads a pixel never written.
  logic [COORD_BITS-1:0] plan_dx [LABELS];
  logic [COORD_BITS-1:0] plan_dy [LABELS];
  logic [SIZE_BITS-1:0]  plan_width;
  logic [SIZE_BITS-1:0]  plan_height;
  bit                    pix_known [IMAGE_SIDE*IMAGE_SIDE];

  logic [SIZE_BITS-1:0] phase_width  [PHASES] = '{256, 511, 1, 0, 16, 256, 0};
  logic [SIZE_BITS-1:0] phase_height [PHASES] = '{256, 300, 1, 256, 12, 1, 0};

  shift_map_seam_cost u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .query   (qry),
    .result  (res)
  );

  seam_cost_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .qry         (qry),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random backpressure, plus one long hold-off on request so
  // the result queue fills and the block has to drop query.ready.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request <= 1'b0;
        res.ready    <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Every field random; the base of all other items.
  function automatic seam_item_t noise_item();
    seam_item_t it;
    it.op    = op_t'(2'($urandom));
    it.x1    = COORD_BITS'($urandom);
    it.y1    = COORD_BITS'($urandom);
    it.x2    = COORD_BITS'($urandom);
    it.y2    = COORD_BITS'($urandom);
    it.l1    = LABEL_BITS'($urandom);
    it.l2    = LABEL_BITS'($urandom);
    it.value = PIX_BITS'($urandom);
    it.dx    = COORD_BITS'($urandom);
    it.dy    = COORD_BITS'($urandom);
    return it;
  endfunction

  function automatic seam_item_t shaped(input op_t op, input int x1, y1, x2, y2, l1, l2,
                                        input int value);
    seam_item_t it;
    it       = noise_item();
    it.op    = op;
    it.x1    = COORD_BITS'(x1);
    it.y1    = COORD_BITS'(y1);
    it.x2    = COORD_BITS'(x2);
    it.y2    = COORD_BITS'(y2);
    it.l1    = LABEL_BITS'(l1);
    it.l2    = LABEL_BITS'(l2);
    it.value = PIX_BITS'(value);
    return it;
  endfunction

  // Gray levels lean on the extremes so the largest costs show up.
  function automatic logic [PIX_BITS-1:0] gray_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return PIX_BITS'($urandom);
    endcase
  endfunction

  // Mostly small shifts keep labels compatible; some span the full range.
  function automatic logic [COORD_BITS-1:0] wide_shift();
    int r;
    r = $urandom_range(99);
    if (r < 70) return COORD_BITS'($urandom_range(15));
    if (r < 90) return COORD_BITS'($urandom_range(255));
    return COORD_BITS'($urandom_range(COORD_MAX));
  endfunction

  // Pick a coordinate that lands inside under both shifts, or one step past
  // either edge now and then; fall back to noise when no such value exists.
  function automatic logic [COORD_BITS-1:0] aim(input int s1, s2, side);
    int lo, hi;
    lo = (s1 > s2) ? s1 : s2;
    hi = ((s1 < s2) ? s1 : s2) + side - 1;
    if (hi > COORD_MAX) hi = COORD_MAX;
    if (lo > hi) return COORD_BITS'($urandom_range(COORD_MAX));
    case ($urandom_range(9))
      0:       return COORD_BITS'(lo - 1);
      1:       return COORD_BITS'(hi + 1);
      default: return COORD_BITS'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic seam_item_t random_item();
    seam_item_t it;
    int r, w, h;
    it = noise_item();
    w  = used_side(plan_width);
    h  = used_side(plan_height);
    r  = $urandom_range(99);
    if (r < 12) begin
      it.op = OP_PIX_WR;
      if ($urandom_range(3) != 0) begin
        it.x1 = COORD_BITS'($urandom_range(IMAGE_SIDE - 1));
        it.y1 = COORD_BITS'($urandom_range(IMAGE_SIDE - 1));
      end
      it.value = gray_value();
    end else if (r < 20) begin
      it.op = OP_SHIFT_WR;
      it.dx = wide_shift();
      it.dy = wide_shift();
    end else if (r < 45) begin
      it.op = OP_UNARY;
      if ($urandom_range(4) != 0) begin
        it.x1 = aim(plan_dx[it.l1], plan_dx[it.l1], w);
        it.y1 = aim(plan_dy[it.l1], plan_dy[it.l1], h);
      end
    end else begin
      it.op = OP_PAIR;
      // Leave a share of pairs as pure noise; aim the rest at the image.
      if ($urandom_range(99) >= 15) begin
        if ($urandom_range(9) == 0) it.l2 = it.l1;
        it.x1 = aim(plan_dx[it.l1], plan_dx[it.l2], w);
        it.y1 = aim(plan_dy[it.l1], plan_dy[it.l2], h);
        case ($urandom_range(4))
          0, 1: begin
            it.x2 = it.x1 + 1'b1;
            it.y2 = it.y1;
          end
          2, 3: begin
            it.x2 = it.x1;
            it.y2 = it.y1 + 1'b1;
          end
          default: begin
            it.x2 = aim(plan_dx[it.l1], plan_dx[it.l2], w);
            it.y2 = aim(plan_dy[it.l1], plan_dy[it.l2], h);
          end
        endcase
      end
    end
    return it;
  endfunction

  // Offer one item and hold it until accepted; idle gaps come first.
  task automatic offer_item(input seam_item_t it);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      qry.valid <= 1'b0;
      @(posedge clk);
    end
    qry.valid         <= 1'b1;
    qry.opcode        <= it.op;
    qry.first_node_x  <= it.x1;
    qry.first_node_y  <= it.y1;
    qry.second_node_x <= it.x2;
    qry.second_node_y <= it.y2;
    qry.first_label   <= it.l1;
    qry.second_label  <= it.l2;
    qry.pixel_value   <= it.value;
    qry.shift_dx      <= it.dx;
    qry.shift_dy      <= it.dy;
    do @(posedge clk); while (!qry.ready);
    if (it.op == OP_PIX_WR && it.x1 < IMAGE_SIDE && it.y1 < IMAGE_SIDE)
      pix_known[{it.y1[7:0], it.x1[7:0]}] = 1'b1;
    if (it.op == OP_SHIFT_WR) begin
      plan_dx[it.l1] = it.dx;
      plan_dy[it.l1] = it.dy;
    end
  endtask

  task automatic fill_pixel(input logic [PIX_BITS-1:0] x, y);
    if (!pix_known[{y, x}])
      offer_item(shaped(OP_PIX_WR, x, y, $urandom, $urandom, $urandom, $urandom,
                        gray_value()));
  endtask

  // A pairwise query with distinct labels reads four pixels when all four
  // placements land inside: write any of them not loaded yet, then send it.
  task automatic issue_item(input seam_item_t it);
    logic [PIX_BITS-1:0] ax, ay, bx, by, cx, cy, ex, ey;
    bit all_in;
    int w, h;
    w = used_side(plan_width);
    h = used_side(plan_height);
    if (it.op == OP_PAIR && it.l1 != it.l2) begin
      all_in = lands_inside(it.x1, it.y1, plan_dx[it.l1], plan_dy[it.l1], w, h, ax, ay) &
               lands_inside(it.x1, it.y1, plan_dx[it.l2], plan_dy[it.l2], w, h, cx, cy) &
               lands_inside(it.x2, it.y2, plan_dx[it.l1], plan_dy[it.l1], w, h, ex, ey) &
               lands_inside(it.x2, it.y2, plan_dx[it.l2], plan_dy[it.l2], w, h, bx, by);
      if (all_in) begin
        fill_pixel(ax, ay);
        fill_pixel(cx, cy);
        fill_pixel(ex, ey);
        fill_pixel(bx, by);
      end
    end
    offer_item(it);
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_drained();
    qry.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Setup and access cycle; random upper bits must not reach the register.
  task automatic reg_write(input reg_idx_t idx, input logic [SIZE_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (APB_DATA_BITS'($urandom) << SIZE_BITS) | APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_WIDTH) plan_width = value;
    else plan_height = value;
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    qry.valid         <= 1'b0;
    qry.opcode        <= OP_PIX_WR;
    qry.first_node_x  <= '0;
    qry.first_node_y  <= '0;
    qry.second_node_x <= '0;
    qry.second_node_y <= '0;
    qry.first_label   <= '0;
    qry.second_label  <= '0;
    qry.pixel_value   <= '0;
    qry.shift_dx      <= '0;
    qry.shift_dy      <= '0;
    hold_request      <= 1'b0;
    src_idle_pct      = IDLE_PCT;
    snk_idle_pct      = IDLE_PCT;
    plan_width        = SIZE_RESET;
    plan_height       = SIZE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Load the whole shift table before any query reads it. Label 0 gets no shift
    // and labels 1..2 unit shifts for the hand-built cases; label 63 sits at the far corner.
    for (int l = 0; l < LABELS; l++) begin
      seam_item_t it;
      it    = noise_item();
      it.op = OP_SHIFT_WR;
      it.l1 = LABEL_BITS'(l);
      it.dx = wide_shift();
      it.dy = wide_shift();
      if (l == 0) {it.dx, it.dy} = '0;
      if (l == 1) {it.dx, it.dy} = {COORD_BITS'(1), COORD_BITS'(0)};
      if (l == 2) {it.dx, it.dy} = {COORD_BITS'(0), COORD_BITS'(1)};
      if (l == LABELS - 1) {it.dx, it.dy} = '1;
      offer_item(it);
    end

    // Largest cost: 0 / 255 / 0 along a row, labels shifted by one column.
    offer_item(shaped(OP_PIX_WR, 0, 0, 0, 0, 0, 0, 0));
    offer_item(shaped(OP_PIX_WR, 1, 0, 0, 0, 0, 0, 255));
    offer_item(shaped(OP_PIX_WR, 2, 0, 0, 0, 0, 0, 0));
    issue_item(shaped(OP_PAIR, 1, 0, 2, 0, 0, 1, 0));
    // Equal labels cost nothing even far outside the image.
    issue_item(shaped(OP_PAIR, 1023, 1023, 1023, 0, 5, 5, 0));
    // One placement falls left of the image.
    issue_item(shaped(OP_PAIR, 0, 0, 1, 0, 0, 1, 0));
    // Writes outside pixel storage are dropped; the corner write inside is kept.
    offer_item(shaped(OP_PIX_WR, 256, 3, 0, 0, 0, 0, 255));
    offer_item(shaped(OP_PIX_WR, 5, 1023, 0, 0, 0, 0, 255));
    offer_item(shaped(OP_PIX_WR, 255, 255, 0, 0, 0, 0, 255));
    // Unary at the corners and one step past each edge.
    issue_item(shaped(OP_UNARY, 0, 0, 0, 0, 0, 0, 0));
    issue_item(shaped(OP_UNARY, 255, 255, 0, 0, 0, 0, 0));
    issue_item(shaped(OP_UNARY, 256, 0, 0, 0, 0, 0, 0));
    issue_item(shaped(OP_UNARY, 0, 256, 0, 0, 0, 0, 0));
    issue_item(shaped(OP_UNARY, 1023, 1023, 0, 0, 63, 0, 0));
    issue_item(shaped(OP_UNARY, 1022, 1023, 0, 0, 63, 0, 0));
    issue_item(shaped(OP_UNARY, 0, 0, 0, 0, 1, 0, 0));
    // Pair at the bottom-right corner, shifted one row apart.
    issue_item(shaped(OP_PAIR, 255, 255, 254, 255, 0, 2, 0));
    issue_item(shaped(OP_PAIR, 255, 255, 255, 256, 0, 2, 0));

    // Random phases, each under its own image size. Phase 0 keeps the reset
    // sizes, phase 1 runs with no idling on either side, the last is random.
    phase_width[PHASES-1]  = SIZE_BITS'($urandom_range(511, 1));
    phase_height[PHASES-1] = SIZE_BITS'($urandom_range(511, 1));
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        // Writes give no result; let the last one clear the pipe.
        repeat (SETTLE_CYCLES) @(posedge clk);
        reg_write(REG_WIDTH, phase_width[p]);
        reg_write(REG_HEIGHT, phase_height[p]);
      end
      src_idle_pct = (p == 1) ? 0 : IDLE_PCT;
      snk_idle_pct = (p == 1) ? 0 : IDLE_PCT;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Starve the result side while queries keep coming.
        if (p == 0 && n == 60) hold_request <= 1'b1;
        // Pause the query side until the block has answered everything.
        if (p == 0 && n == 120) wait_drained();
        issue_item(random_item());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
